// ===== rtl/nmt_pkg.sv =====
package nmt_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP_EXT = 2'd0,
    OP_LOOKUP_INT = 2'd1,
    OP_INSERT     = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_MISS      = 3'd0,
    ST_HIT       = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_TICK_DONE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_SCAN  = 3'd1,
    SQ_ALLOC = 3'd2,
    SQ_DONE  = 3'd3
  } seq_t;

  localparam logic        REG_EXT_ADDRESS  = 1'b0;
  localparam logic        REG_ICMP_LIMIT   = 1'b1;
  localparam logic [15:0] ICMP_LIMIT_RESET = 16'd60;
  localparam logic [15:0] TCP_BASE         = 16'd1024;
  localparam logic [15:0] ICMP_BASE        = 16'd0;
  localparam logic        KIND_ICMP        = 1'b0;

  typedef struct packed {
    op_t         op;
    logic [15:0] ext_id;
    logic [31:0] int_address;
    logic [15:0] int_id;
    logic        req_type;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] int_address;
    logic [15:0] int_id;
    logic [15:0] ext_id;
    logic [31:0] created;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic        found_type;
    logic [31:0] int_address;
    logic [15:0] int_id;
    logic [31:0] ext_address;
    logic [15:0] ext_id;
    logic [6:0]  removed;
  } result_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ===== rtl/nat_mapping_table.sv =====
// NAT mapping table.
// Input channel (in_valid/in_stall): op 0 looks up by in_ext_id, op 1 by
// in_int_address/in_int_id, op 2 inserts a mapping of type in_req_type, op 3
// is the one-second tick that ages out ICMP mappings.
// Output channel (out_valid/out_stall): exactly one result per item, in order.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 external
// address, 1 ICMP idle limit). The user must write only while no item is in
// flight; the block itself does not enforce it.
// A lookup or tick scans the whole entry memory, reading one entry per cycle;
// an insert then, if it found a free entry, searches up to TABLE_ENTRIES
// candidate ids for one not in use. The next item leaves the queue only after
// the previous result has moved into the output register.
// A two-deep input queue takes new items while the table is busy.
// Reset clears every mapping, the seconds counter and the queues; the external
// address resets to 0 and the idle limit to 60.
// When the receiver stalls the result holds in the output register; the next
// item is still scanned, but its result waits in SQ_DONE until that one moves.
module nat_mapping_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_ext_id,
  input  logic [31:0] in_int_address,
  input  logic [15:0] in_int_id,
  input  logic        in_req_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_found_type,
  output logic [31:0] out_found_int_address,
  output logic [15:0] out_found_int_id,
  output logic [31:0] out_found_ext_address,
  output logic [15:0] out_found_ext_id,
  output logic [6:0]  out_removed_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]          ext_address_r;
  logic [15:0]          icmp_limit_r;
  nmt_pkg::queue_head_t head;
  logic                 pop;
  nmt_pkg::result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_address_r <= '0;
      icmp_limit_r  <= nmt_pkg::ICMP_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nmt_pkg::REG_EXT_ADDRESS: ext_address_r <= cfg_wdata;
        nmt_pkg::REG_ICMP_LIMIT:  icmp_limit_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  nmt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_ext_id     (in_ext_id),
    .in_int_address(in_int_address),
    .in_int_id     (in_int_id),
    .in_req_type   (in_req_type),
    .head          (head),
    .pop           (pop)
  );

  nmt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .external_address(ext_address_r),
    .icmp_idle_limit (icmp_limit_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_res         (res)
  );

  assign out_status            = res.status;
  assign out_found_type        = res.found_type;
  assign out_found_int_address = res.int_address;
  assign out_found_int_id      = res.int_id;
  assign out_found_ext_address = res.ext_address;
  assign out_found_ext_id      = res.ext_id;
  assign out_removed_count     = res.removed;

endmodule

// ===== rtl/nmt_ram.sv =====
module nmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nmt_front.sv =====
module nmt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_ext_id,
  input  logic [31:0]         in_int_address,
  input  logic [15:0]         in_int_id,
  input  logic                in_req_type,
  output nmt_pkg::queue_head_t head,
  input  logic                pop
);

  nmt_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, take;
  nmt_pkg::cmd_t cmd_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign take     = pop && (cnt_r != 2'd0);

  always_comb begin
    cmd_in.op          = nmt_pkg::op_t'(in_op);
    cmd_in.ext_id      = in_ext_id;
    cmd_in.int_address = in_int_address;
    cmd_in.int_id      = in_int_id;
    cmd_in.req_type    = in_req_type;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = slot_r[rd_ptr_r];

endmodule

// ===== rtl/nmt_back.sv =====
module nmt_back #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nmt_pkg::queue_head_t head,
  output logic                 pop,
  input  logic [31:0]          external_address,
  input  logic [15:0]          icmp_idle_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nmt_pkg::result_t     out_res
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT  = CW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_CAND = AW'(TABLE_ENTRIES - 1);
  localparam logic [16:0]   SPAN      = 17'(TABLE_ENTRIES);
  localparam int EW = $bits(nmt_pkg::entry_t);

  nmt_pkg::seq_t    state_r, state_nxt;
  nmt_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TABLE_ENTRIES-1:0] taken_r, taken_nxt;
  logic             hit_r, hit_nxt;
  logic             free_found_r, free_found_nxt;
  logic [AW-1:0]    free_idx_r, free_idx_nxt;
  logic [AW-1:0]    cand_r, cand_nxt;
  logic [6:0]       removed_r, removed_nxt;
  logic [31:0]      now_r, now_nxt;
  nmt_pkg::result_t res_r, res_nxt;
  nmt_pkg::result_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  nmt_pkg::entry_t  ram_wdata, ent;
  logic [EW-1:0]    ram_rdata;

  logic             ent_v;
  logic [15:0]      base, off;
  logic [31:0]      age;

  nmt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ent   = nmt_pkg::entry_t'(ram_rdata);
  assign ent_v = valid_r[chk_idx_r];
  assign base  = cmd_r.req_type ? nmt_pkg::TCP_BASE : nmt_pkg::ICMP_BASE;
  assign off   = ent.ext_id - base;
  assign age   = now_r - ent.created;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    valid_nxt      = valid_r;
    taken_nxt      = taken_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cand_nxt       = cand_r;
    removed_nxt    = removed_r;
    now_nxt        = now_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = free_idx_r;
    ram_raddr      = cnt_r[AW-1:0];
    ram_wdata.kind        = cmd_r.req_type;
    ram_wdata.int_address = cmd_r.int_address;
    ram_wdata.int_id      = cmd_r.int_id;
    ram_wdata.ext_id      = base + 16'(cand_r);
    ram_wdata.created     = now_r;

    unique case (state_r)
      nmt_pkg::SQ_IDLE: begin
        if (head.valid) begin
          pop            = 1'b1;
          cmd_nxt        = head.cmd;
          cnt_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          taken_nxt      = '0;
          removed_nxt    = '0;
          res_nxt        = '0;
          res_nxt.status = nmt_pkg::ST_MISS;
          if (head.cmd.op == nmt_pkg::OP_TICK) begin
            now_nxt = now_r + 32'd1;
          end
          state_nxt = nmt_pkg::SQ_SCAN;
        end
      end
      nmt_pkg::SQ_SCAN: begin
        if (cnt_r != LAST_CNT) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt     = cnt_r + CW'(1);
        end
        if (chk_vld_r) begin
          case (cmd_r.op) inside
            nmt_pkg::OP_LOOKUP_EXT, nmt_pkg::OP_LOOKUP_INT: begin
              if (ent_v && !hit_r &&
                  (((cmd_r.op == nmt_pkg::OP_LOOKUP_EXT) && (ent.ext_id == cmd_r.ext_id)) ||
                   ((cmd_r.op == nmt_pkg::OP_LOOKUP_INT) &&
                    (ent.int_address == cmd_r.int_address) &&
                    (ent.int_id == cmd_r.int_id)))) begin
                hit_nxt             = 1'b1;
                res_nxt.status      = nmt_pkg::ST_HIT;
                res_nxt.found_type  = ent.kind;
                res_nxt.int_address = ent.int_address;
                res_nxt.int_id      = ent.int_id;
                res_nxt.ext_address = external_address;
                res_nxt.ext_id      = ent.ext_id;
              end
            end
            nmt_pkg::OP_INSERT: begin
              if (!ent_v && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = chk_idx_r;
              end
              if (ent_v && (ent.kind == cmd_r.req_type) && (ent.ext_id >= base) &&
                  ({1'b0, off} < SPAN)) begin
                taken_nxt[off[AW-1:0]] = 1'b1;
              end
            end
            default: begin
              if (ent_v && (ent.kind == nmt_pkg::KIND_ICMP) &&
                  (age >= {16'd0, icmp_idle_limit})) begin
                valid_nxt[chk_idx_r] = 1'b0;
                removed_nxt          = removed_r + 7'd1;
              end
            end
          endcase
        end
        if ((cnt_r == LAST_CNT) && !chk_vld_r) begin
          state_nxt = nmt_pkg::SQ_DONE;
          if (cmd_r.op == nmt_pkg::OP_TICK) begin
            res_nxt.status  = nmt_pkg::ST_TICK_DONE;
            res_nxt.removed = removed_r;
          end else if (cmd_r.op == nmt_pkg::OP_INSERT) begin
            if (free_found_r) begin
              cand_nxt  = '0;
              state_nxt = nmt_pkg::SQ_ALLOC;
            end else begin
              res_nxt.status = nmt_pkg::ST_FULL;
            end
          end
        end
      end
      nmt_pkg::SQ_ALLOC: begin
        if (!taken_r[cand_r]) begin
          ram_we                  = 1'b1;
          valid_nxt[free_idx_r]   = 1'b1;
          res_nxt.status          = nmt_pkg::ST_INSERTED;
          res_nxt.found_type      = cmd_r.req_type;
          res_nxt.int_address     = cmd_r.int_address;
          res_nxt.int_id          = cmd_r.int_id;
          res_nxt.ext_address     = external_address;
          res_nxt.ext_id          = base + 16'(cand_r);
          state_nxt               = nmt_pkg::SQ_DONE;
        end else if (cand_r == LAST_CAND) begin
          res_nxt.status = nmt_pkg::ST_FULL;
          state_nxt      = nmt_pkg::SQ_DONE;
        end else begin
          cand_nxt = cand_r + AW'(1);
        end
      end
      nmt_pkg::SQ_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = nmt_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_nxt = nmt_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nmt_pkg::SQ_IDLE;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cnt_r        <= cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    taken_r      <= taken_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    cand_r       <= cand_nxt;
    removed_r    <= removed_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == nmt_pkg::SQ_IDLE) && head.valid)
    else $error("queue popped outside idle");
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_r[ram_waddr])
    else $error("insert overwrites a live entry");
  a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == nmt_pkg::SQ_SCAN))
    else $error("entry check outside scan");
  a_tick_status: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == nmt_pkg::SQ_DONE) && (cmd_r.op == nmt_pkg::OP_TICK))
      |-> (res_r.status == nmt_pkg::ST_TICK_DONE))
    else $error("tick finished with wrong status");
`endif

endmodule
